// File: hdl/escape_time_fractal_iterator_defines.svh
// ----------------------------------------------------------------------------
// Escape-time fractal iterator assertion macros
// Shorthand for clocked properties, sampled on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH

// Same-cycle implication.
`define ETFI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ETFI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/etfi_pkg.sv
// ----------------------------------------------------------------------------
// etfi_pkg
// Widths, register indexes, shared types and the saturation helper.
// ----------------------------------------------------------------------------
package etfi_pkg;

  localparam int WORD_WIDTH      = 32;
  localparam int FRACTION_BITS   = 28;
  localparam int COUNT_WIDTH     = 16;
  localparam int MODE_WIDTH      = 2;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = WORD_WIDTH;

  localparam int PROD_WIDTH = 2 * WORD_WIDTH;
  localparam int MAG_WIDTH  = PROD_WIDTH + 1;
  localparam int SUM_WIDTH  = PROD_WIDTH - FRACTION_BITS + 3;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [SUM_WIDTH-1:0]  sum_t;
  typedef logic [COUNT_WIDTH-1:0]       count_t;
  typedef logic [MODE_WIDTH-1:0]        mode_t;
  typedef logic [CFG_INDEX_WIDTH-1:0]   cfg_index_t;
  typedef logic [CFG_DATA_WIDTH-1:0]    cfg_data_t;

  // Products of one complex square.
  typedef struct packed {
    prod_t rr;
    prod_t ii;
    prod_t ri;
  } csq_prod_t;

  // Iteration rules; the unused code iterates as Mandelbrot.
  localparam mode_t MODE_MANDELBROT   = 2'd0;
  localparam mode_t MODE_JULIA        = 2'd1;
  localparam mode_t MODE_BURNING_SHIP = 2'd2;

  // Register indexes.
  localparam cfg_index_t REG_MODE   = 8'd0;
  localparam cfg_index_t REG_LIMIT  = 8'd1;
  localparam cfg_index_t REG_KRE    = 8'd2;
  localparam cfg_index_t REG_KIM    = 8'd3;

  localparam count_t LIMIT_RESET = COUNT_WIDTH'(256);

  // 4.0 at the scale of a full-width square.
  localparam logic [MAG_WIDTH-1:0] ESCAPE_BOUND =
    MAG_WIDTH'(1) << (2 * FRACTION_BITS + 2);

  function automatic word_t sat_word(input sum_t v);
    sum_t hi;
    sum_t lo;
    hi = SUM_WIDTH'($signed({1'b0, {(WORD_WIDTH-1){1'b1}}}));
    lo = SUM_WIDTH'($signed({1'b1, {(WORD_WIDTH-1){1'b0}}}));
    if (v > hi) begin
      return {1'b0, {(WORD_WIDTH-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(WORD_WIDTH-1){1'b0}}};
    end
    return v[WORD_WIDTH-1:0];
  endfunction

endpackage

// File: hdl/etfi_if.sv
// ----------------------------------------------------------------------------
// etfi channel interfaces
// Valid/ready channels for points, results and register writes.
// ----------------------------------------------------------------------------
interface etfi_in_if;
  logic          valid;
  logic          ready;
  etfi_pkg::word_t point_re;
  etfi_pkg::word_t point_im;

  modport source (output valid, output point_re, output point_im, input ready);
  modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

interface etfi_out_if;
  logic             valid;
  logic             ready;
  etfi_pkg::count_t iterations;
  logic             escaped;

  modport source (output valid, output iterations, output escaped, input ready);
  modport sink   (input valid, input iterations, input escaped, output ready);
endinterface

interface etfi_cfg_if;
  logic                 valid;
  logic                 ready;
  etfi_pkg::cfg_index_t index;
  etfi_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/escape_time_fractal_iterator.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Escape-time count for one pixel (Mandelbrot, Julia or Burning Ship).
// ----------------------------------------------------------------------------
// Usage:
//   in_if   carries one point c (point_re, point_im, signed Q4.28) per beat.
//   out_if  returns one beat per point: iterations and the escaped flag.
//   cfg_if  writes a register (index, data); always ready, write only while
//           no point is in flight.
// Iteration: each update runs ST_MUL, which registers the three products of
//   the shared complex square unit, then ST_UPD, which tests the magnitude
//   and forms the saturated new z. in_if.ready rises again in the same cycle
//   as the result is loaded into the output register, so only one point is
//   in flight at a time.
// Stall: the result sits in an output register. If it is still waiting when
//   the next point finishes, hold that point in its last step until the
//   output register frees.
// Reset (rst_n low, synchronous): back to idle, output empty, registers to
//   Mandelbrot, limit 256, Julia constant 0.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator (
  input logic          clk,
  input logic          rst_n,
  etfi_in_if.sink      in_if,
  etfi_out_if.source   out_if,
  etfi_cfg_if.sink     cfg_if
);

  localparam int SHW = etfi_pkg::PROD_WIDTH - etfi_pkg::FRACTION_BITS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  etfi_pkg::mode_t  mode_r;
  etfi_pkg::count_t limit_r;
  etfi_pkg::word_t  kre_r;
  etfi_pkg::word_t  kim_r;

  // Working point.
  etfi_pkg::word_t  zr_r, zr_nxt;
  etfi_pkg::word_t  zi_r, zi_nxt;
  etfi_pkg::word_t  ar_r, ar_nxt;
  etfi_pkg::word_t  ai_r, ai_nxt;
  etfi_pkg::count_t count_r, count_nxt;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  etfi_pkg::count_t out_iter_r, out_iter_nxt;
  logic             out_esc_r, out_esc_nxt;

  etfi_pkg::csq_prod_t prod_r;

  logic [etfi_pkg::MAG_WIDTH-1:0] mag;
  logic                           escape;
  logic                           done;
  logic                           out_free;
  logic signed [SHW-1:0]          rr_sh;
  logic signed [SHW-1:0]          ii_sh;
  logic signed [SHW:0]            ri_sh;
  logic signed [etfi_pkg::PROD_WIDTH:0] ri_ext;
  logic signed [etfi_pkg::PROD_WIDTH:0] ri_abs;
  logic signed [SHW+1:0]          abs_sh;
  etfi_pkg::sum_t                 re_sum;
  etfi_pkg::sum_t                 im_sum;

  etfi_csq u_csq (
    .clk    (clk),
    .zr     (zr_r),
    .zi     (zi_r),
    .prod_r (prod_r)
  );

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid      = out_valid_r;
  assign out_if.iterations = out_iter_r;
  assign out_if.escaped    = out_esc_r;

  assign out_free = !out_valid_r || out_if.ready;

  // Magnitude test and next z from the registered products.
  always_comb begin
    mag    = {1'b0, prod_r.rr} + {1'b0, prod_r.ii};
    escape = (mag > etfi_pkg::ESCAPE_BOUND);
    done   = escape || (count_r >= limit_r);

    // Floor shifts drop the extra fraction bits; the cross term keeps one
    // more bit to double it.
    rr_sh  = $signed(prod_r.rr[etfi_pkg::PROD_WIDTH-1:etfi_pkg::FRACTION_BITS]);
    ii_sh  = $signed(prod_r.ii[etfi_pkg::PROD_WIDTH-1:etfi_pkg::FRACTION_BITS]);
    ri_sh  = $signed(prod_r.ri[etfi_pkg::PROD_WIDTH-1:etfi_pkg::FRACTION_BITS-1]);
    ri_ext = (etfi_pkg::PROD_WIDTH+1)'(prod_r.ri);
    ri_abs = prod_r.ri[etfi_pkg::PROD_WIDTH-1] ? -ri_ext : ri_ext;
    abs_sh = $signed(ri_abs[etfi_pkg::PROD_WIDTH:etfi_pkg::FRACTION_BITS-1]);

    re_sum = etfi_pkg::SUM_WIDTH'(rr_sh) - etfi_pkg::SUM_WIDTH'(ii_sh)
           + etfi_pkg::SUM_WIDTH'(ar_r);
    if (mode_r == etfi_pkg::MODE_BURNING_SHIP) begin
      im_sum = etfi_pkg::SUM_WIDTH'(ai_r) - etfi_pkg::SUM_WIDTH'(abs_sh);
    end else begin
      im_sum = etfi_pkg::SUM_WIDTH'(ai_r) + etfi_pkg::SUM_WIDTH'(ri_sh);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    ar_nxt        = ar_r;
    ai_nxt        = ai_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_iter_nxt  = out_iter_r;
    out_esc_nxt   = out_esc_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          // Start at z = c; the addend is c, or k in Julia mode.
          zr_nxt    = in_if.point_re;
          zi_nxt    = in_if.point_im;
          ar_nxt    = (mode_r == etfi_pkg::MODE_JULIA) ? kre_r : in_if.point_re;
          ai_nxt    = (mode_r == etfi_pkg::MODE_JULIA) ? kim_r : in_if.point_im;
          count_nxt = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (done) begin
          // Hold here until the output register can take the result.
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_iter_nxt  = count_r;
            out_esc_nxt   = escape;
            state_nxt     = ST_IDLE;
          end
        end else begin
          zr_nxt    = etfi_pkg::sat_word(re_sum);
          zi_nxt    = etfi_pkg::sat_word(im_sum);
          count_nxt = count_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zr_r       <= zr_nxt;
    zi_r       <= zi_nxt;
    ar_r       <= ar_nxt;
    ai_r       <= ai_nxt;
    count_r    <= count_nxt;
    out_iter_r <= out_iter_nxt;
    out_esc_r  <= out_esc_nxt;
  end

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= etfi_pkg::MODE_MANDELBROT;
      limit_r <= etfi_pkg::LIMIT_RESET;
      kre_r   <= '0;
      kim_r   <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        etfi_pkg::REG_MODE:  mode_r  <= cfg_if.data[etfi_pkg::MODE_WIDTH-1:0];
        etfi_pkg::REG_LIMIT: limit_r <= cfg_if.data[etfi_pkg::COUNT_WIDTH-1:0];
        etfi_pkg::REG_KRE:   kre_r   <= cfg_if.data[etfi_pkg::WORD_WIDTH-1:0];
        etfi_pkg::REG_KIM:   kim_r   <= cfg_if.data[etfi_pkg::WORD_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hdl/etfi_csq.sv
// ----------------------------------------------------------------------------
// etfi_csq
// Complex square unit: registers zr^2, zi^2 and zr*zi at full width.
// ----------------------------------------------------------------------------
module etfi_csq (
  input  logic                 clk,
  input  etfi_pkg::word_t      zr,
  input  etfi_pkg::word_t      zi,
  output etfi_pkg::csq_prod_t  prod_r
);

  always_ff @(posedge clk) begin
    prod_r.rr <= etfi_pkg::PROD_WIDTH'(zr) * etfi_pkg::PROD_WIDTH'(zr);
    prod_r.ii <= etfi_pkg::PROD_WIDTH'(zi) * etfi_pkg::PROD_WIDTH'(zi);
    prod_r.ri <= etfi_pkg::PROD_WIDTH'(zr) * etfi_pkg::PROD_WIDTH'(zi);
  end

endmodule

// File: hdl/etfi_checker.sv
// ----------------------------------------------------------------------------
// etfi_checker
// Port-level checks on the escape-time iterator, bound to the top level.
// ----------------------------------------------------------------------------
`include "escape_time_fractal_iterator_defines.svh"

module etfi_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input etfi_pkg::count_t     out_iterations,
  input logic                 out_escaped,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input etfi_pkg::cfg_index_t cfg_index,
  input etfi_pkg::cfg_data_t  cfg_data
);

  logic             in_beat;
  etfi_pkg::count_t limit_r;

  assign in_beat = in_valid && in_ready;

  // Shadow copy of the iteration limit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= etfi_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready && cfg_index == etfi_pkg::REG_LIMIT) begin
      limit_r <= cfg_data[etfi_pkg::COUNT_WIDTH-1:0];
    end
  end

  `ETFI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_iterations) && $stable(out_escaped), "result changed while stalled")
  `ETFI_ASSERT_NXT(a_busy_after_in, in_beat, !in_ready && !$rose(out_valid), "not busy after a point beat")
  `ETFI_ASSERT_IMP(a_no_escape_at_limit, out_valid && !out_escaped, out_iterations == limit_r, "bounded point stopped short of the limit")
  `ETFI_ASSERT_IMP(a_count_in_range, out_valid, out_iterations <= limit_r, "count beyond the limit")

endmodule

bind escape_time_fractal_iterator etfi_checker u_etfi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_iterations (out_if.iterations),
  .out_escaped    (out_if.escaped),
  .cfg_valid      (cfg_if.valid),
  .cfg_ready      (cfg_if.ready),
  .cfg_index      (cfg_if.index),
  .cfg_data       (cfg_if.data)
);

// File: dv/tb_escape_time_fractal_iterator.sv
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_iterator
// Self-checking bench for the escape-time iterator: each point beat is scored
// against a local fixed-point predictor of the Mandelbrot, Julia and Burning
// Ship rules, across register settings and randomized idle on both channels.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_iterator;
  timeunit 1ns;
  timeprecision 1ps;

  // Q4.28 landmarks used by the directed cases.
  localparam etfi_pkg::word_t Q_ZERO = 32'sh0000_0000;
  localparam etfi_pkg::word_t Q_HALF = 32'sh0800_0000;
  localparam etfi_pkg::word_t Q_ONE  = 32'sh1000_0000;
  localparam etfi_pkg::word_t Q_TWO  = 32'sh2000_0000;
  localparam etfi_pkg::word_t Q_MAX  = 32'sh7fff_ffff;
  localparam etfi_pkg::word_t Q_MIN  = 32'sh8000_0000;

  // Index that decodes to no register; a write there must change nothing.
  localparam etfi_pkg::cfg_index_t REG_UNUSED = 8'hff;

  // |z|^2 bound of 4.0 at the scale of a full-width square.
  localparam logic signed [65:0] MAG_BOUND =
    66'sd1 <<< (2 * etfi_pkg::FRACTION_BITS + 2);

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // Items per random phase.
  localparam int RANDOM_ITEMS = 462;

  typedef struct packed {
    etfi_pkg::count_t iterations;
    logic             escaped;
  } escape_result_t;

  logic clk;
  logic rst_n;

  etfi_in_if  point_bus ();
  etfi_out_if result_bus ();
  etfi_cfg_if reg_bus ();

  escape_time_fractal_iterator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (point_bus),
    .out_if (result_bus),
    .cfg_if (reg_bus)
  );

  // Shadow copy of the register file, updated on each accepted write beat.
  etfi_pkg::mode_t  cur_mode;
  etfi_pkg::count_t cur_limit;
  etfi_pkg::word_t  cur_kre;
  etfi_pkg::word_t  cur_kim;

  // Predicted counts waiting for their result beat, oldest first.
  escape_result_t pending_counts[$];

  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Clamp an exact sum back to the signed word range.
  function automatic etfi_pkg::word_t clamp_word(input longint v);
    if (v > SAT_HI) begin
      return Q_MAX;
    end else if (v < SAT_LO) begin
      return Q_MIN;
    end
    return etfi_pkg::word_t'(v);
  endfunction

  // Run the escape-time loop for point c under the shadow settings.
  function automatic escape_result_t predict_escape(input etfi_pkg::word_t cr,
                                                    input etfi_pkg::word_t ci);
    escape_result_t res;
    etfi_pkg::word_t zr;
    etfi_pkg::word_t zi;
    etfi_pkg::word_t ar;
    etfi_pkg::word_t ai;
    longint rr;
    longint ii;
    longint ri;
    longint ri_abs;
    longint nre;
    longint nim;
    logic signed [65:0] mag;
    int unsigned n;
    logic esc;
    zr = cr;
    zi = ci;
    ar = cr;
    ai = ci;
    n = 0;
    esc = 1'b0;
    // Julia adds the constant k; every other code adds the point itself.
    if (cur_mode == etfi_pkg::MODE_JULIA) begin
      ar = cur_kre;
      ai = cur_kim;
    end
    while (1'b1) begin
      rr = longint'(zr) * longint'(zr);
      ii = longint'(zi) * longint'(zi);
      ri = longint'(zr) * longint'(zi);
      mag = rr;
      mag = mag + ii;
      // Magnitude test comes before the limit test, so an escape on the
      // last allowed step still reports escaped.
      if (mag > MAG_BOUND) begin
        esc = 1'b1;
        break;
      end
      if (n >= cur_limit) break;
      nre = (rr >>> etfi_pkg::FRACTION_BITS) - (ii >>> etfi_pkg::FRACTION_BITS)
          + longint'(ar);
      if (cur_mode == etfi_pkg::MODE_BURNING_SHIP) begin
        ri_abs = (ri < 0) ? -ri : ri;
        nim = -(ri_abs >>> (etfi_pkg::FRACTION_BITS - 1)) + longint'(ai);
      end else begin
        nim = (ri >>> (etfi_pkg::FRACTION_BITS - 1)) + longint'(ai);
      end
      zr = clamp_word(nre);
      zi = clamp_word(nim);
      n++;
    end
    res.iterations = etfi_pkg::count_t'(n);
    res.escaped = esc;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Drive one register write beat; called and returns at a falling edge.
  task automatic write_reg(input etfi_pkg::cfg_index_t idx,
                           input etfi_pkg::cfg_data_t value);
    reg_bus.index = idx;
    reg_bus.data  = value;
    reg_bus.valid = 1'b1;
    @(posedge clk);
    while (!reg_bus.ready) @(posedge clk);
    case (idx)
      etfi_pkg::REG_MODE:
        cur_mode  = etfi_pkg::mode_t'(value[etfi_pkg::MODE_WIDTH-1:0]);
      etfi_pkg::REG_LIMIT:
        cur_limit = etfi_pkg::count_t'(value[etfi_pkg::COUNT_WIDTH-1:0]);
      etfi_pkg::REG_KRE:   cur_kre   = etfi_pkg::word_t'(value);
      etfi_pkg::REG_KIM:   cur_kim   = etfi_pkg::word_t'(value);
      default: ;
    endcase
    @(negedge clk);
    reg_bus.valid = 1'b0;
  endtask

  // Send one point beat, idling first at the phase's rate, and queue its
  // predicted count at the accepting edge.
  task automatic send_point(input etfi_pkg::word_t re, input etfi_pkg::word_t im);
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    point_bus.point_re = re;
    point_bus.point_im = im;
    point_bus.valid    = 1'b1;
    @(posedge clk);
    while (!point_bus.ready) @(posedge clk);
    pending_counts.push_back(predict_escape(re, im));
    @(negedge clk);
    point_bus.valid = 1'b0;
  endtask

  // Hold the sender until every predicted count has been scored, then let
  // the block settle back to idle.
  task automatic wait_drained();
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_all(input etfi_pkg::mode_t m, input etfi_pkg::count_t lim,
                           input etfi_pkg::word_t kre, input etfi_pkg::word_t kim);
    write_reg(etfi_pkg::REG_MODE, etfi_pkg::cfg_data_t'(m));
    write_reg(etfi_pkg::REG_LIMIT, etfi_pkg::cfg_data_t'(lim));
    write_reg(etfi_pkg::REG_KRE, etfi_pkg::cfg_data_t'(kre));
    write_reg(etfi_pkg::REG_KIM, etfi_pkg::cfg_data_t'(kim));
  endtask

  // Random coordinate: mostly inside +/-2 where the orbits get interesting,
  // sometimes anywhere in the word.
  function automatic etfi_pkg::word_t pick_coord();
    if ($urandom_range(0, 4) == 0) return etfi_pkg::word_t'($urandom);
    return etfi_pkg::word_t'($urandom_range(0, 32'h4000_0000)) - Q_TWO;
  endfunction

  // Random Julia constant: mostly within +/-1, sometimes full range.
  function automatic etfi_pkg::word_t pick_const();
    if ($urandom_range(0, 3) == 0) return etfi_pkg::word_t'($urandom);
    return etfi_pkg::word_t'($urandom_range(0, 32'h2000_0000)) - Q_ONE;
  endfunction

  // --------------------------------------------------------------------------
  // Result scoreboard: score every result beat against the oldest prediction.
  // --------------------------------------------------------------------------
  initial begin
    result_bus.ready = 1'b1;
    forever begin
      @(negedge clk);
      result_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    escape_result_t exp_res;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result beat iterations=%0d escaped=%0b",
                 $time, result_bus.iterations, result_bus.escaped);
        mismatch_count++;
      end else begin
        exp_res = pending_counts.pop_front();
        if (result_bus.iterations !== exp_res.iterations) begin
          $display("%0t: iterations mismatch expected=%0d actual=%0d",
                   $time, exp_res.iterations, result_bus.iterations);
          mismatch_count++;
        end
        if (result_bus.escaped !== exp_res.escaped) begin
          $display("%0t: escaped mismatch expected=%0b actual=%0b",
                   $time, exp_res.escaped, result_bus.escaped);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: Mandelbrot, limit 256, k = 0. A write to an unused index
  // must leave them alone.
  task automatic test_reset_defaults();
    write_reg(REG_UNUSED, etfi_pkg::cfg_data_t'($urandom));
    send_point(Q_ZERO, Q_ZERO);      // inside: runs to the limit
    send_point(Q_MIN, Q_MIN);        // most negative corner
    send_point(Q_MAX, Q_MAX);        // most positive corner
    send_point(Q_TWO, Q_ZERO);       // |c|^2 exactly 4: not yet escaped
    send_point(Q_TWO + 1, Q_ZERO);   // just past the bound
    send_point(-Q_TWO, Q_ZERO);      // -2.0 maps to the fixed point 2.0
    send_point(Q_ZERO, Q_TWO);       // on the bound along the imaginary axis
    wait_drained();
  endtask

  // Zero limit: no update, only the magnitude test on c.
  task automatic test_zero_limit();
    write_reg(etfi_pkg::REG_LIMIT, etfi_pkg::cfg_data_t'(0));
    send_point(Q_ZERO, Q_ZERO);
    send_point(Q_TWO + 1, Q_ZERO);
    send_point(Q_TWO, Q_ZERO);
    wait_drained();
  endtask

  // Escape on the last allowed update still flags escaped.
  task automatic test_escape_at_limit();
    write_reg(etfi_pkg::REG_LIMIT, etfi_pkg::cfg_data_t'(1));
    send_point(Q_TWO, Q_ZERO);
    wait_drained();
  endtask

  // Unused mode code iterates as Mandelbrot; upper data bits are dropped.
  task automatic test_unused_mode();
    write_reg(etfi_pkg::REG_MODE, 32'hffff_ffff);
    write_reg(etfi_pkg::REG_LIMIT, 32'hffff_0100);
    send_point(-32'sh0c00_0000, 32'sh0199_999a);
    send_point(Q_HALF, -Q_HALF);
    wait_drained();
  endtask

  // Julia: a classic constant, then both constant extremes.
  task automatic test_julia();
    write_all(etfi_pkg::MODE_JULIA, etfi_pkg::count_t'(256), -32'sh0ccc_cccd,
              32'sh027e_f9db);
    send_point(Q_ZERO, Q_ZERO);
    send_point(Q_ONE, Q_ZERO);
    wait_drained();
    write_reg(etfi_pkg::REG_KRE, etfi_pkg::cfg_data_t'(Q_MIN));
    write_reg(etfi_pkg::REG_KIM, etfi_pkg::cfg_data_t'(Q_MAX));
    send_point(Q_ZERO, Q_ZERO);
    wait_drained();
    write_reg(etfi_pkg::REG_KRE, etfi_pkg::cfg_data_t'(Q_MAX));
    write_reg(etfi_pkg::REG_KIM, etfi_pkg::cfg_data_t'(Q_MIN));
    send_point(Q_ONE, Q_ZERO);
    wait_drained();
  endtask

  // Burning Ship: absolute value on the cross term.
  task automatic test_burning_ship();
    write_all(etfi_pkg::MODE_BURNING_SHIP, etfi_pkg::count_t'(256), Q_ZERO, Q_ZERO);
    send_point(-32'sh1c00_0000, -32'sh007a_e148);
    send_point(Q_HALF, -Q_HALF);
    wait_drained();
  endtask

  // Largest limit: one fast escape and one point that runs every step.
  task automatic test_max_limit();
    write_all(etfi_pkg::MODE_MANDELBROT, etfi_pkg::count_t'(16'hffff), Q_ZERO, Q_ZERO);
    send_point(Q_TWO + 1, Q_ONE);
    send_point(Q_ZERO, Q_ZERO);
    wait_drained();
  endtask

  // Random traffic in batches; each batch drains, then rolls new settings.
  // Unused register bits are filled with noise on every write.
  task automatic test_random_traffic(input int items, input int idle_pct,
                                     input int stall_pct);
    int batch_left;
    int pick;
    etfi_pkg::mode_t m;
    etfi_pkg::count_t lim;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    batch_left = 0;
    for (int i = 0; i < items; i++) begin
      if (batch_left == 0) begin
        wait_drained();
        m = etfi_pkg::mode_t'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        // Keep most limits small so the run stays short; a few go long.
        if (pick == 0) lim = etfi_pkg::count_t'($urandom_range(100, 300));
        else if (pick == 1) lim = etfi_pkg::count_t'($urandom_range(0, 3));
        else lim = etfi_pkg::count_t'($urandom_range(4, 48));
        write_reg(etfi_pkg::REG_MODE,
                  ($urandom & ~etfi_pkg::cfg_data_t'(3)) | etfi_pkg::cfg_data_t'(m));
        write_reg(etfi_pkg::REG_LIMIT, {16'($urandom), lim});
        write_reg(etfi_pkg::REG_KRE, etfi_pkg::cfg_data_t'(pick_const()));
        write_reg(etfi_pkg::REG_KIM, etfi_pkg::cfg_data_t'(pick_const()));
        batch_left = $urandom_range(30, 60);
      end
      send_point(pick_coord(), pick_coord());
      batch_left--;
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    point_bus.valid = 1'b0;
    point_bus.point_re = '0;
    point_bus.point_im = '0;
    reg_bus.valid = 1'b0;
    reg_bus.index = '0;
    reg_bus.data = '0;
    cur_mode = etfi_pkg::MODE_MANDELBROT;
    cur_limit = etfi_pkg::LIMIT_RESET;
    cur_kre = Q_ZERO;
    cur_kim = Q_ZERO;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // Synchronous reset, released on a falling edge.
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_zero_limit();
    test_escape_at_limit();
    test_unused_mode();
    test_julia();
    test_burning_ship();
    test_max_limit();

    test_random_traffic(RANDOM_ITEMS, 0, 0);
    test_random_traffic(RANDOM_ITEMS, 59, 0);
    test_random_traffic(RANDOM_ITEMS, 0, 59);
    test_random_traffic(RANDOM_ITEMS, 19, 19);

    // Allow for a stray late beat after the last expected one.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/etfi_pkg.sv
hdl/etfi_if.sv
hdl/etfi_csq.sv
hdl/escape_time_fractal_iterator.sv
hdl/etfi_checker.sv
dv/tb_escape_time_fractal_iterator.sv
